FILE: rtl/core/ictp_pkg.sv
// ----------------------------------------------------------------------------
// ictp_pkg: IDE channel timing programmer shared definitions
// Clock-count timing tables, result types and packing constants.
// ----------------------------------------------------------------------------
package ictp_pkg;

	// Timing values are counts of 30 ns clocks, already rounded up from ns.
	localparam int CLK_W = 5;

	typedef logic [CLK_W-1:0] clk_cnt_t;

	typedef struct packed {
		clk_cnt_t setup;
		clk_cnt_t active8;
		clk_cnt_t recover8;
		clk_cnt_t cycle8;
		clk_cnt_t active;
		clk_cnt_t recover;
		clk_cnt_t cycle;
	} pio_clk_t;

	typedef struct packed {
		clk_cnt_t setup;
		clk_cnt_t active;
		clk_cnt_t recover;
		clk_cnt_t cycle;
	} dma_clk_t;

	// Per-drive result handed from the drive calculator to the top level.
	typedef struct packed {
		logic [7:0] data_timing;
		clk_cnt_t   active8;
		clk_cnt_t   recover8;
		logic [1:0] setup_field;
	} drive_timing_t;

	localparam logic [2:0] PIO_MODE_MAX = 3'd4;
	localparam logic [1:0] DMA_MODE_MAX = 2'd2;

	localparam clk_cnt_t CLK_MIN       = 5'd1;
	localparam clk_cnt_t CLK_MAX       = 5'd16;
	localparam clk_cnt_t SETUP_CLK_MAX = 5'd4;

	localparam logic [7:0] DATA_ABSENT  = 8'ha8;
	localparam logic [7:0] CMD_NO_DRIVE = 8'hff;
	localparam logic [7:0] SETUP_RESET  = 8'hff;
	localparam logic [1:0] SETUP_ABSENT = 2'b11;

	// PIO modes 0..4, ns values ceil-divided by 30.
	function automatic pio_clk_t pio_lookup(input logic [2:0] mode);
		pio_clk_t t;
		case (mode)
			3'd0: t = '{5'd3, 5'd10, 5'd8, 5'd20, 5'd6, 5'd5, 5'd20};
			3'd1: t = '{5'd2, 5'd10, 5'd4, 5'd13, 5'd5, 5'd4, 5'd13};
			3'd2: t = '{5'd1, 5'd10, 5'd2, 5'd11, 5'd4, 5'd3, 5'd8};
			3'd3: t = '{5'd1, 5'd3,  5'd3, 5'd6,  5'd3, 5'd3, 5'd6};
			3'd4: t = '{5'd1, 5'd3,  5'd1, 5'd4,  5'd3, 5'd1, 5'd4};
			default: t = '0;
		endcase
		return t;
	endfunction

	// Multiword DMA modes 0..2, ns values ceil-divided by 30.
	function automatic dma_clk_t dma_lookup(input logic [1:0] mode);
		dma_clk_t t;
		case (mode)
			2'd0: t = '{5'd2, 5'd8, 5'd8, 5'd16};
			2'd1: t = '{5'd2, 5'd3, 5'd2, 5'd5};
			2'd2: t = '{5'd1, 5'd3, 5'd1, 5'd4};
			default: t = '0;
		endcase
		return t;
	endfunction

	// Pack a clamped active/recovery pair as (active-1)<<4 | (recovery-1).
	function automatic logic [7:0] pack_timing(input clk_cnt_t act, input clk_cnt_t rec);
		clk_cnt_t a1;
		clk_cnt_t r1;
		a1 = act - CLK_MIN;
		r1 = rec - CLK_MIN;
		return {a1[3:0], r1[3:0]};
	endfunction

endpackage

FILE: rtl/core/ictp_drive_calc.sv
// ----------------------------------------------------------------------------
// ictp_drive_calc: per-drive timing calculation
// Looks up PIO and DMA timing table entries, merges, stretches, clamps and packs.
// ----------------------------------------------------------------------------
module ictp_drive_calc
	import ictp_pkg::*;
(
	input  logic [2:0]    pio_mode,
	input  logic          uses_mwdma,
	input  logic [1:0]    dma_mode,
	output drive_timing_t timing
);

	// Grow active and recovery to fill the cycle; active takes the smaller half.
	function automatic logic [2*CLK_W-1:0] stretch(input clk_cnt_t a, input clk_cnt_t r,
			input clk_cnt_t c);
		logic [CLK_W:0] sum;
		logic [CLK_W:0] gap;
		clk_cnt_t       an;
		clk_cnt_t       rn;
		sum = {1'b0, a} + {1'b0, r};
		gap = {1'b0, c} - sum;
		if (sum < {1'b0, c}) begin
			an = a + gap[CLK_W:1];
			rn = c - an;
		end else begin
			an = a;
			rn = r;
		end
		return {an, rn};
	endfunction

	function automatic clk_cnt_t clamp(input clk_cnt_t v, input clk_cnt_t hi);
		clk_cnt_t res;
		if (v < CLK_MIN) begin
			res = CLK_MIN;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = v;
		end
		return res;
	endfunction

	pio_clk_t             pio;
	dma_clk_t             dma;
	clk_cnt_t             setup;
	clk_cnt_t             active;
	clk_cnt_t             recover;
	clk_cnt_t             cycle;
	logic [2*CLK_W-1:0]   str8;
	logic [2*CLK_W-1:0]   str;
	clk_cnt_t             setup_c;

	always_comb begin
		pio     = pio_lookup(pio_mode);
		dma     = dma_lookup(dma_mode);
		setup   = pio.setup;
		active  = pio.active;
		recover = pio.recover;
		cycle   = pio.cycle;
		if (uses_mwdma) begin
			setup   = (dma.setup   > setup)   ? dma.setup   : setup;
			active  = (dma.active  > active)  ? dma.active  : active;
			recover = (dma.recover > recover) ? dma.recover : recover;
			cycle   = (dma.cycle   > cycle)   ? dma.cycle   : cycle;
		end
		str8    = stretch(pio.active8, pio.recover8, pio.cycle8);
		str     = stretch(active, recover, cycle);
		setup_c = clamp(setup, SETUP_CLK_MAX);

		timing.active8     = clamp(str8[2*CLK_W-1:CLK_W], CLK_MAX);
		timing.recover8    = clamp(str8[CLK_W-1:0], CLK_MAX);
		timing.data_timing = pack_timing(clamp(str[2*CLK_W-1:CLK_W], CLK_MAX),
			clamp(str[CLK_W-1:0], CLK_MAX));
		setup_c            = setup_c - CLK_MIN;
		timing.setup_field = setup_c[1:0];
	end

endmodule

FILE: rtl/core/ide_channel_timing_programmer.sv
// ----------------------------------------------------------------------------
// ide_channel_timing_programmer: ATA PIO / multiword DMA timing byte builder
// Computes data, command and address setup timing bytes for one channel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  request  | in        | start / busy        | channel_select, unit0_*, unit1_*
//  result   | out       | done (1-cycle)      | accepted, channel_echo, timing bytes
//  config   | in        | cfg_valid/cfg_ready | cfg_data (controller_supported)
//
//  A request is taken on any edge with start high; busy stays low, so one
//  request per clock is sustained. The request register feeds the table
//  lookup, merge, stretch and clamp logic, which lands in the result
//  register; the done strobe is registered alongside the result.
//  The setup byte store is updated on the same edge as the result register,
//  so back-to-back requests see each other's setup fields.
//  Reset clears the request and result strobes, restores the setup byte to
//  all-ones and marks the controller supported. The receiver cannot stall.
//
module ide_channel_timing_programmer
	import ictp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       start,
	output logic       busy,
	input  logic       channel_select,
	input  logic       unit0_present,
	input  logic [2:0] unit0_pio_mode,
	input  logic       unit0_uses_mwdma,
	input  logic [1:0] unit0_dma_mode,
	input  logic       unit1_present,
	input  logic [2:0] unit1_pio_mode,
	input  logic       unit1_uses_mwdma,
	input  logic [1:0] unit1_dma_mode,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// result channel
	output logic       done,
	output logic       accepted,
	output logic       channel_echo,
	output logic [7:0] data_timing_unit0,
	output logic [7:0] data_timing_unit1,
	output logic [7:0] command_timing,
	output logic [7:0] setup_timing_byte
);

	// Request register.
	logic       valid_s1;
	logic       chan_s1;
	logic       u0_present_s1;
	logic [2:0] u0_pio_s1;
	logic       u0_dma_s1;
	logic [1:0] u0_dmode_s1;
	logic       u1_present_s1;
	logic [2:0] u1_pio_s1;
	logic       u1_dma_s1;
	logic [1:0] u1_dmode_s1;

	// Result register.
	logic       done_s2;
	logic       accepted_s2;
	logic       chan_s2;
	logic [7:0] data0_s2;
	logic [7:0] data1_s2;
	logic [7:0] cmd_s2;
	logic [7:0] setup_s2;

	logic       supported_q;
	logic [7:0] setup_q;

	drive_timing_t t0;
	drive_timing_t t1;

	logic       mode_ok;
	logic       req_ok;
	logic [7:0] data0_n;
	logic [7:0] data1_n;
	logic [7:0] cmd_n;
	logic [7:0] setup_n;
	logic [1:0] f0;
	logic [1:0] f1;
	clk_cnt_t   cmd_act;
	clk_cnt_t   cmd_rec;

	// Never stall a request: the whole computation fits between two registers.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supported_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			supported_q <= cfg_data;
		end
	end

	// Capture the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			chan_s1       <= channel_select;
			u0_present_s1 <= unit0_present;
			u0_pio_s1     <= unit0_pio_mode;
			u0_dma_s1     <= unit0_uses_mwdma;
			u0_dmode_s1   <= unit0_dma_mode;
			u1_present_s1 <= unit1_present;
			u1_pio_s1     <= unit1_pio_mode;
			u1_dma_s1     <= unit1_uses_mwdma;
			u1_dmode_s1   <= unit1_dma_mode;
		end
	end

	ictp_drive_calc u_drive0 (
		.pio_mode   (u0_pio_s1),
		.uses_mwdma (u0_dma_s1),
		.dma_mode   (u0_dmode_s1),
		.timing     (t0)
	);

	ictp_drive_calc u_drive1 (
		.pio_mode   (u1_pio_s1),
		.uses_mwdma (u1_dma_s1),
		.dma_mode   (u1_dmode_s1),
		.timing     (t1)
	);

	always_comb begin
		// Modes of an absent drive don't matter; a bad mode on a present one
		// rejects the whole request.
		mode_ok = 1'b1;
		if (u0_present_s1 && ((u0_pio_s1 > PIO_MODE_MAX) ||
				(u0_dma_s1 && (u0_dmode_s1 > DMA_MODE_MAX)))) begin
			mode_ok = 1'b0;
		end
		if (u1_present_s1 && ((u1_pio_s1 > PIO_MODE_MAX) ||
				(u1_dma_s1 && (u1_dmode_s1 > DMA_MODE_MAX)))) begin
			mode_ok = 1'b0;
		end
		req_ok = mode_ok && supported_q;

		data0_n = u0_present_s1 ? t0.data_timing : DATA_ABSENT;
		data1_n = u1_present_s1 ? t1.data_timing : DATA_ABSENT;
		f0      = u0_present_s1 ? t0.setup_field : SETUP_ABSENT;
		f1      = u1_present_s1 ? t1.setup_field : SETUP_ABSENT;

		// Command timing takes the maxima over present drives only.
		cmd_act = '0;
		cmd_rec = '0;
		if (u0_present_s1) begin
			cmd_act = t0.active8;
			cmd_rec = t0.recover8;
		end
		if (u1_present_s1) begin
			cmd_act = (t1.active8  > cmd_act) ? t1.active8  : cmd_act;
			cmd_rec = (t1.recover8 > cmd_rec) ? t1.recover8 : cmd_rec;
		end
		cmd_n = (u0_present_s1 || u1_present_s1) ? pack_timing(cmd_act, cmd_rec)
			: CMD_NO_DRIVE;

		// Master sits above slave; primary channel owns the upper nibble.
		setup_n = setup_q;
		if (chan_s1) begin
			setup_n[3:0] = {f0, f1};
		end else begin
			setup_n[7:4] = {f0, f1};
		end
	end

	// Hold the other channel's setup fields; advance only on a good request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= SETUP_RESET;
		end else if (valid_s1 && req_ok) begin
			setup_q <= setup_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	// Drop all timing bytes to zero on a rejected request.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			accepted_s2 <= req_ok;
			chan_s2     <= chan_s1;
			data0_s2    <= req_ok ? data0_n : 8'h00;
			data1_s2    <= req_ok ? data1_n : 8'h00;
			cmd_s2      <= req_ok ? cmd_n   : 8'h00;
			setup_s2    <= req_ok ? setup_n : 8'h00;
		end
	end

	assign done              = done_s2;
	assign accepted          = accepted_s2;
	assign channel_echo      = chan_s2;
	assign data_timing_unit0 = data0_s2;
	assign data_timing_unit1 = data1_s2;
	assign command_timing    = cmd_s2;
	assign setup_timing_byte = setup_s2;

endmodule

FILE: rtl/core/ictp_checker.sv
// ----------------------------------------------------------------------------
// ictp_checker: port-level checks for the IDE channel timing programmer
// Watches request/result ordering and rejected/no-drive result contents.
// ----------------------------------------------------------------------------
module ictp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       channel_select,
	input logic       unit0_present,
	input logic       unit1_present,
	input logic       done,
	input logic       accepted,
	input logic       channel_echo,
	input logic [7:0] data_timing_unit0,
	input logic [7:0] data_timing_unit1,
	input logic [7:0] command_timing,
	input logic [7:0] setup_timing_byte
);

	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request produced no result");

	a_result_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a request");

	a_channel_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (channel_echo == $past(channel_select, 2)))
		else $error("channel echo does not match request");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> ((data_timing_unit0 == 8'h00) &&
			(data_timing_unit1 == 8'h00) && (command_timing == 8'h00) &&
			(setup_timing_byte == 8'h00)))
		else $error("rejected result carries timing bytes");

	a_no_drive_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted && !$past(unit0_present, 2) && !$past(unit1_present, 2))
			|-> (command_timing == 8'hff))
		else $error("command timing wrong with no drive present");

endmodule

bind ide_channel_timing_programmer ictp_checker u_ictp_checker (.*);

FILE: tb/ide_channel_timing_checker.sv
// ----------------------------------------------------------------------------
// ide_channel_timing_checker: timing byte predictor and result scoreboard
// Watches the request, configuration and result channels of the IDE channel
// timing programmer. Computes the timing bytes each accepted request should
// produce and compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module ide_channel_timing_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       channel_select,
	input  logic       unit0_present,
	input  logic [2:0] unit0_pio_mode,
	input  logic       unit0_uses_mwdma,
	input  logic [1:0] unit0_dma_mode,
	input  logic       unit1_present,
	input  logic [2:0] unit1_pio_mode,
	input  logic       unit1_uses_mwdma,
	input  logic [1:0] unit1_dma_mode,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       done,
	input  logic       accepted,
	input  logic       channel_echo,
	input  logic [7:0] data_timing_unit0,
	input  logic [7:0] data_timing_unit1,
	input  logic [7:0] command_timing,
	input  logic [7:0] setup_timing_byte,
	output int         outstanding,
	output int         mismatches
);

	localparam logic [7:0] ABSENT_DATA      = 8'ha8;
	localparam logic [7:0] NO_DRIVE_COMMAND = 8'hff;
	localparam logic [7:0] SETUP_AT_RESET   = 8'hff;
	localparam logic [1:0] ABSENT_SETUP     = 2'b11;
	localparam logic [2:0] PIO_MODE_LAST    = 3'd4;
	localparam logic [1:0] DMA_MODE_LAST    = 2'd2;
	localparam int         REPORT_CAP       = 100;

	typedef struct packed {
		logic       accepted;
		logic       channel;
		logic [7:0] data0;
		logic [7:0] data1;
		logic [7:0] command;
		logic [7:0] setup;
	} timing_bytes_t;

	typedef struct packed {
		logic [9:0] setup;
		logic [9:0] active8;
		logic [9:0] recover8;
		logic [9:0] cycle8;
		logic [9:0] active;
		logic [9:0] recover;
		logic [9:0] cycle;
	} pio_ns_t;

	typedef struct packed {
		logic [9:0] setup;
		logic [9:0] active;
		logic [9:0] recover;
		logic [9:0] cycle;
	} dma_ns_t;

	typedef struct packed {
		int unsigned setup;
		int unsigned active8;
		int unsigned recover8;
		int unsigned active;
		int unsigned recover;
	} drive_clocks_t;

	timing_bytes_t timing_q[$];
	timing_bytes_t want;
	logic [7:0]    setup_kept;
	logic          supported_copy;

	// ATA PIO timings in ns: setup, 8-bit active/recovery/cycle, data active/recovery/cycle
	function automatic pio_ns_t pio_ns(input logic [2:0] mode);
		case (mode)
			3'd0:    return {10'd70, 10'd290, 10'd240, 10'd600, 10'd165, 10'd150, 10'd600};
			3'd1:    return {10'd50, 10'd290, 10'd93,  10'd383, 10'd125, 10'd100, 10'd383};
			3'd2:    return {10'd30, 10'd290, 10'd40,  10'd330, 10'd100, 10'd90,  10'd240};
			3'd3:    return {10'd30, 10'd80,  10'd70,  10'd180, 10'd80,  10'd70,  10'd180};
			default: return {10'd25, 10'd70,  10'd25,  10'd120, 10'd70,  10'd25,  10'd120};
		endcase
	endfunction

	// Multiword DMA timings in ns: setup, active, recovery, cycle
	function automatic dma_ns_t dma_ns(input logic [1:0] mode);
		case (mode)
			2'd0:    return {10'd60, 10'd215, 10'd215, 10'd480};
			2'd1:    return {10'd45, 10'd80,  10'd50,  10'd150};
			default: return {10'd25, 10'd70,  10'd25,  10'd120};
		endcase
	endfunction

	function automatic int unsigned ns_to_clk(input int unsigned ns);
		return (ns + 29) / 30;
	endfunction

	function automatic int unsigned max2(input int unsigned a, input int unsigned b);
		return (a > b) ? a : b;
	endfunction

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Widen active and recovery to fill the cycle; returns {active, recovery}
	function automatic logic [63:0] fill_cycle(input int unsigned act, input int unsigned rec,
			input int unsigned cyc);
		int unsigned gap;
		if (act + rec >= cyc)
			return {act, rec};
		gap = cyc - act - rec;
		act = act + gap / 2;
		return {act, cyc - act};
	endfunction

	function automatic logic [7:0] pack_pair(input int unsigned act, input int unsigned rec);
		logic [3:0] a;
		logic [3:0] r;
		a = 4'(act - 1);
		r = 4'(rec - 1);
		return {a, r};
	endfunction

	function automatic drive_clocks_t drive_clocks(input logic [2:0] pio, input logic dma,
			input logic [1:0] dmode);
		pio_ns_t       p;
		dma_ns_t       d;
		drive_clocks_t c;
		int unsigned   cyc8;
		int unsigned   cyc;
		logic [63:0]   pair;
		p = pio_ns(pio);
		c.setup    = ns_to_clk(p.setup);
		c.active8  = ns_to_clk(p.active8);
		c.recover8 = ns_to_clk(p.recover8);
		cyc8       = ns_to_clk(p.cycle8);
		c.active   = ns_to_clk(p.active);
		c.recover  = ns_to_clk(p.recover);
		cyc        = ns_to_clk(p.cycle);
		if (dma) begin
			d = dma_ns(dmode);
			c.setup   = max2(c.setup, ns_to_clk(d.setup));
			c.active  = max2(c.active, ns_to_clk(d.active));
			c.recover = max2(c.recover, ns_to_clk(d.recover));
			cyc       = max2(cyc, ns_to_clk(d.cycle));
		end
		pair = fill_cycle(c.active8, c.recover8, cyc8);
		c.active8  = clamp(pair[63:32], 1, 16);
		c.recover8 = clamp(pair[31:0], 1, 16);
		pair = fill_cycle(c.active, c.recover, cyc);
		c.active   = clamp(pair[63:32], 1, 16);
		c.recover  = clamp(pair[31:0], 1, 16);
		c.setup    = clamp(c.setup, 1, 4);
		return c;
	endfunction

	function automatic timing_bytes_t predict_timing(input logic enabled, input logic [7:0] kept,
			input logic ch, input logic [1:0] present, input logic [5:0] pio,
			input logic [1:0] dma, input logic [3:0] dmode);
		timing_bytes_t   r;
		drive_clocks_t   c;
		logic [7:0]      setup;
		logic [1:0][7:0] data;
		int unsigned     cmd_a;
		int unsigned     cmd_r;
		logic            any_present;
		logic            ok;
		int              chn;
		int              sh;
		ok = enabled;
		for (int u = 0; u < 2; u++)
			if (present[u] && (pio[u*3 +: 3] > PIO_MODE_LAST
					|| (dma[u] && dmode[u*2 +: 2] > DMA_MODE_LAST)))
				ok = 1'b0;
		r = '0;
		r.channel = ch;
		if (!ok)
			return r;
		chn = int'(ch);
		setup = kept;
		cmd_a = 0;
		cmd_r = 0;
		any_present = 1'b0;
		for (int u = 0; u < 2; u++) begin
			sh = (3 - (chn * 2 + u)) * 2;
			setup[sh +: 2] = ABSENT_SETUP;
			data[u] = ABSENT_DATA;
		end
		for (int u = 0; u < 2; u++) begin
			if (present[u]) begin
				sh = (3 - (chn * 2 + u)) * 2;
				c = drive_clocks(pio[u*3 +: 3], dma[u], dmode[u*2 +: 2]);
				data[u] = pack_pair(c.active, c.recover);
				setup[sh +: 2] = 2'(c.setup - 1);
				cmd_a = max2(cmd_a, c.active8);
				cmd_r = max2(cmd_r, c.recover8);
				any_present = 1'b1;
			end
		end
		r.accepted = 1'b1;
		r.data0    = data[0];
		r.data1    = data[1];
		r.command  = any_present ? pack_pair(cmd_a, cmd_r) : NO_DRIVE_COMMAND;
		r.setup    = setup;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int wanted);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, wanted);
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.delete();
			setup_kept     = SETUP_AT_RESET;
			supported_copy = 1'b1;
			outstanding   <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				supported_copy = cfg_data;
			if (done) begin
				if (timing_q.size() == 0) begin
					report("result with no request pending, accepted", accepted, 0);
				end else begin
					want = timing_q.pop_front();
					if (accepted !== want.accepted)
						report("accepted", accepted, want.accepted);
					if (channel_echo !== want.channel)
						report("channel_echo", channel_echo, want.channel);
					if (data_timing_unit0 !== want.data0)
						report("data_timing_unit0", data_timing_unit0, want.data0);
					if (data_timing_unit1 !== want.data1)
						report("data_timing_unit1", data_timing_unit1, want.data1);
					if (command_timing !== want.command)
						report("command_timing", command_timing, want.command);
					if (setup_timing_byte !== want.setup)
						report("setup_timing_byte", setup_timing_byte, want.setup);
				end
			end
			if (start && !busy) begin
				want = predict_timing(supported_copy, setup_kept, channel_select,
					{unit1_present, unit0_present}, {unit1_pio_mode, unit0_pio_mode},
					{unit1_uses_mwdma, unit0_uses_mwdma}, {unit1_dma_mode, unit0_dma_mode});
				if (want.accepted)
					setup_kept = want.setup;
				timing_q.push_back(want);
			end
			outstanding <= timing_q.size();
		end
	end

endmodule

FILE: tb/ide_channel_timing_programmer_tb.sv
// ----------------------------------------------------------------------------
// ide_channel_timing_programmer_tb: top level of the timing programmer bench
// Drives directed and random channel requests with varying sender gaps,
// toggles the controller-supported register between phases, and leaves all
// prediction and comparison to the checker instance beside the block.
// ----------------------------------------------------------------------------
module ide_channel_timing_programmer_tb;

	// Cycles without any handshake before the run is declared hung. The
	// slowest correct phase idles on 88 percent of cycles, so long gaps are
	// already rare; this leaves ample margin.
	localparam int WATCHDOG_LIMIT = 4000;
	// The result register follows the request register; wait a little longer at the end.
	localparam int TAIL_CYCLES    = 8;
	localparam int PHASE_ITEMS    = 470;
	localparam int NOISE_PCT      = 15;

	logic       clk              = 1'b0;
	logic       arst_n           = 1'b0;
	logic       start            = 1'b0;
	logic       busy;
	logic       channel_select   = 1'b0;
	logic       unit0_present    = 1'b0;
	logic [2:0] unit0_pio_mode   = '0;
	logic       unit0_uses_mwdma = 1'b0;
	logic [1:0] unit0_dma_mode   = '0;
	logic       unit1_present    = 1'b0;
	logic [2:0] unit1_pio_mode   = '0;
	logic       unit1_uses_mwdma = 1'b0;
	logic [1:0] unit1_dma_mode   = '0;
	logic       cfg_valid        = 1'b0;
	logic       cfg_ready;
	logic       cfg_data         = 1'b0;
	logic       done;
	logic       accepted;
	logic       channel_echo;
	logic [7:0] data_timing_unit0;
	logic [7:0] data_timing_unit1;
	logic [7:0] command_timing;
	logic [7:0] setup_timing_byte;

	int outstanding;
	int mismatches;
	int sender_idle_pct = 0;
	int quiet_cycles    = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ide_channel_timing_programmer i_dut (.*);

	ide_channel_timing_checker i_checker (.*);

	// Abort if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL ide_channel_timing_programmer");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request and hold it until the block takes it. Idle cycles
	// before it carry junk on the fields with start low.
	task automatic issue_request(input logic ch,
			input logic p0, input logic [2:0] pio0, input logic dma0, input logic [1:0] dm0,
			input logic p1, input logic [2:0] pio1, input logic dma1, input logic [1:0] dm1);
		while ($urandom_range(99) < sender_idle_pct) begin
			start            <= 1'b0;
			channel_select   <= 1'($urandom);
			unit0_present    <= 1'($urandom);
			unit0_pio_mode   <= 3'($urandom);
			unit0_uses_mwdma <= 1'($urandom);
			unit0_dma_mode   <= 2'($urandom);
			unit1_present    <= 1'($urandom);
			unit1_pio_mode   <= 3'($urandom);
			unit1_uses_mwdma <= 1'($urandom);
			unit1_dma_mode   <= 2'($urandom);
			@(posedge clk);
		end
		start            <= 1'b1;
		channel_select   <= ch;
		unit0_present    <= p0;
		unit0_pio_mode   <= pio0;
		unit0_uses_mwdma <= dma0;
		unit0_dma_mode   <= dm0;
		unit1_present    <= p1;
		unit1_pio_mode   <= pio1;
		unit1_uses_mwdma <= dma1;
		unit1_dma_mode   <= dm1;
		do @(posedge clk); while (busy);
	endtask

	// Mostly legal modes with random presence; the rest is raw noise that
	// reaches the bad-mode rejects and every bit of every field.
	task automatic issue_random_request();
		if ($urandom_range(99) < NOISE_PCT)
			issue_request(1'($urandom), 1'($urandom), 3'($urandom), 1'($urandom),
				2'($urandom), 1'($urandom), 3'($urandom), 1'($urandom), 2'($urandom));
		else
			issue_request(1'($urandom), $urandom_range(3) != 0, 3'($urandom_range(4)),
				1'($urandom), 2'($urandom_range(2)), $urandom_range(3) != 0,
				3'($urandom_range(4)), 1'($urandom), 2'($urandom_range(2)));
	endtask

	// Drop start and wait until every request has its result.
	task automatic drain_requests();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write controller_supported with the block idle.
	task automatic write_supported(input logic value);
		drain_requests();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests, sender idles lightly.
		sender_idle_pct = 17;
		// no drive present on either channel
		issue_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
		issue_request(1, 0, 0, 0, 0, 0, 0, 0, 0);
		// master alone through every PIO mode
		for (int m = 0; m < 5; m++)
			issue_request(0, 1, 3'(m), 0, 0, 0, 0, 0, 0);
		// slave alone with matching DMA modes, then fast PIO over slow DMA
		for (int m = 0; m < 3; m++)
			issue_request(1, 0, 0, 0, 0, 1, 3'(m), 1, 2'(m));
		issue_request(1, 0, 0, 0, 0, 1, 4, 1, 0);
		// mixed speeds so command timing takes maxima across drives
		issue_request(1, 1, 0, 0, 0, 1, 4, 0, 0);
		issue_request(0, 1, 4, 1, 2, 1, 4, 1, 2);
		issue_request(1, 1, 0, 1, 0, 1, 0, 1, 0);
		// bad PIO mode on a present drive rejects
		issue_request(0, 1, 5, 0, 0, 0, 0, 0, 0);
		issue_request(0, 0, 0, 0, 0, 1, 7, 0, 0);
		// bad modes on absent drives are ignored
		issue_request(1, 0, 7, 1, 3, 1, 2, 0, 0);
		// bad DMA mode rejects only when DMA is used
		issue_request(0, 1, 1, 1, 3, 0, 0, 0, 0);
		issue_request(0, 1, 1, 0, 3, 1, 3, 0, 3);
		// every field at its top value
		issue_request(1, 1, 7, 1, 3, 1, 7, 1, 3);
		issue_request(0, 1, 3, 1, 1, 1, 2, 1, 1);

		// Unsupported controller: everything rejects, setup byte must survive.
		write_supported(1'b0);
		issue_request(0, 1, 2, 0, 0, 1, 2, 0, 0);
		issue_request(1, 0, 0, 0, 0, 0, 0, 0, 0);
		issue_request(1, 1, 4, 1, 2, 1, 0, 1, 0);
		write_supported(1'b1);
		issue_request(0, 0, 0, 0, 0, 0, 0, 0, 0);

		// Random phase with a light sender gap.
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_random_request();

		// Short unsupported stretch between phases.
		write_supported(1'b0);
		for (int i = 0; i < 30; i++)
			issue_random_request();
		write_supported(1'b1);

		// Random phase with a heavy sender gap.
		sender_idle_pct = 88;
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_random_request();

		// Back-to-back requests.
		sender_idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_random_request();

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS ide_channel_timing_programmer");
		else
			$display("FAIL ide_channel_timing_programmer");
		$finish;
	end

endmodule
